[design/tct_pkg.sv]
`default_nettype none

package tct_pkg;

	localparam int HOLD_DEPTH_DEF = 16;
	localparam int KW_NUM = 7;
	localparam int KW_MAX_LEN = 6;

	localparam logic [1:0] MODE_BETWEEN = 2'd0;
	localparam logic [1:0] MODE_PLAIN = 2'd1;
	localparam logic [1:0] MODE_QUOTED = 2'd2;

	localparam logic [2:0] CMD_UNKNOWN = 3'd0;
	localparam logic [2:0] CMD_PING = 3'd1;
	localparam logic [2:0] CMD_SET = 3'd2;
	localparam logic [2:0] CMD_GET = 3'd3;
	localparam logic [2:0] CMD_DEL = 3'd4;
	localparam logic [2:0] CMD_EXPIRE = 3'd5;
	localparam logic [2:0] CMD_TTL = 3'd6;
	localparam logic [2:0] CMD_STATS = 3'd7;

	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_BACKSLASH = 8'd92;
	localparam logic [7:0] CH_LOWER_A = 8'd97;
	localparam logic [7:0] CH_LOWER_Z = 8'd122;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	// keyword characters, first character at index 0
	typedef logic [KW_MAX_LEN-1:0][7:0] kw_text_t;

	localparam kw_text_t KW_TEXT [KW_NUM] = '{
		{16'h0000, "GNIP"},
		{24'h000000, "TES"},
		{24'h000000, "TEG"},
		{24'h000000, "LED"},
		{"ERIPXE"},
		{24'h000000, "LTT"},
		{8'h00, "STATS"}
	};

	localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd4, 3'd3, 3'd3, 3'd3, 3'd6, 3'd3, 3'd5};

	typedef struct packed {
		logic load;
		logic rel_start;
		logic rel_step;
		logic main;
		logic eol_bs;
		logic summary;
	} tct_cmd_t;

	typedef struct packed {
		logic need_release;
		logic rel_last;
		logic main_emit;
		logic emit_en;
		logic bs_needed;
		logic eol;
		logic out_free;
	} tct_sts_t;

	typedef struct packed {
		logic kind;
		logic arg_index;
		logic [7:0] arg_byte;
		logic arg_start;
		logic [2:0] command_code;
		logic args_complete;
		logic hold_overflow;
		logic last;
	} tct_res_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic logic [KW_NUM-1:0] kw_mask_next(input logic [KW_NUM-1:0] mask,
			input logic [2:0] pos, input logic [7:0] b);
		logic [KW_NUM-1:0] m;
		logic [7:0] up;
		m = mask;
		up = (b >= CH_LOWER_A && b <= CH_LOWER_Z) ? b - CASE_OFFSET : b;
		for (int k = 0; k < KW_NUM; k++) begin
			if (pos >= KW_LEN[k]) begin
				m[k] = 1'b0;
			end else if (KW_TEXT[k][pos] != up) begin
				m[k] = 1'b0;
			end
		end
		return m;
	endfunction

	function automatic logic [2:0] cmd_code(input logic [1:0] tc,
			input logic [KW_NUM-1:0] mask, input logic [2:0] len);
		logic [2:0] c;
		c = CMD_UNKNOWN;
		if (tc != 2'd0) begin
			for (int k = KW_NUM - 1; k >= 0; k--) begin
				if (mask[k] && KW_LEN[k] == len) begin
					c = 3'(k + 1);
				end
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[design/tct_cmd_if.sv]
`default_nettype none

interface tct_cmd_if;
	logic valid;
	logic ready;
	logic [7:0] byte_value;
	logic byte_valid;
	logic end_of_command;

	modport source(output valid, output byte_value, output byte_valid,
		output end_of_command, input ready);
	modport sink(input valid, input byte_value, input byte_valid,
		input end_of_command, output ready);
endinterface

`default_nettype wire

[design/tct_tok_if.sv]
`default_nettype none

interface tct_tok_if;
	logic valid;
	logic ready;
	logic kind;
	logic arg_index;
	logic [7:0] arg_byte;
	logic arg_start;
	logic [2:0] command_code;
	logic args_complete;
	logic hold_overflow;
	logic last;

	modport source(output valid, output kind, output arg_index, output arg_byte,
		output arg_start, output command_code, output args_complete,
		output hold_overflow, output last, input ready);
	modport sink(input valid, input kind, input arg_index, input arg_byte,
		input arg_start, input command_code, input args_complete,
		input hold_overflow, input last, output ready);
endinterface

`default_nettype wire

[design/text_command_tokenizer.sv]
// text_command_tokenizer: splits a command line into whitespace-separated tokens
// cmd channel: one byte per transfer (byte_value, byte_valid) plus end_of_command;
//   a transfer with byte_valid low carries only the end marker, and one with
//   neither flag set does nothing
// tok channel: argument bytes of the key and value tokens (kind 0) and one
//   summary per line (kind 1) with command code, args_complete and hold_overflow;
//   last marks the final result caused by one cmd transfer
// timing: a transfer registers the byte; each result is then registered in the
//   tok output register; cmd ready returns when the controller is back in IDLE
// quoted whitespace is held in a HOLD_DEPTH-entry ram and released one byte per
//   cycle while tok is not stalled, before the next non-whitespace byte
// end of line adds a pending-backslash step and the summary step
// throughput is set by the controller step sequence feeding one output register
// a stalled tok channel freezes the controller at the next emitting step; cmd
//   ready stays low until every result of the current byte is in the output
//   register
// reset clears the scanner to the between-tokens state with an empty hold ram
`default_nettype none

module text_command_tokenizer #(
	parameter int HOLD_DEPTH = tct_pkg::HOLD_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	tct_cmd_if.sink cmd,
	tct_tok_if.source tok
);

	tct_pkg::tct_cmd_t ctl;
	tct_pkg::tct_sts_t sts;
	tct_pkg::tct_res_t res;
	logic res_valid;
	logic in_ready;

	tct_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cmd.valid),
		.in_ready(in_ready),
		.sts(sts),
		.ctl(ctl)
	);

	tct_dp #(
		.HOLD_DEPTH(HOLD_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.byte_value(cmd.byte_value),
		.byte_valid(cmd.byte_valid),
		.end_of_command(cmd.end_of_command),
		.ctl(ctl),
		.sts(sts),
		.res_valid(res_valid),
		.res_ready(tok.ready),
		.res(res)
	);

	assign cmd.ready = in_ready;
	assign tok.valid = res_valid;
	assign tok.kind = res.kind;
	assign tok.arg_index = res.arg_index;
	assign tok.arg_byte = res.arg_byte;
	assign tok.arg_start = res.arg_start;
	assign tok.command_code = res.command_code;
	assign tok.args_complete = res.args_complete;
	assign tok.hold_overflow = res.hold_overflow;
	assign tok.last = res.last;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("cmd ready high right after a transfer");

	a_idle_no_open_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !(tok.valid && !tok.last))
		else $error("cmd ready while a non-final result is pending");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid && tok.kind |-> tok.last)
		else $error("summary result without last");

	a_summary_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.summary |-> sts.out_free)
		else $error("summary issued with output register occupied");

endmodule

`default_nettype wire

[design/tct_ram.sv]
`default_nettype none

module tct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tct_pkg::HOLD_DEPTH_DEF
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/tct_ctrl.sv]
`default_nettype none

module tct_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tct_pkg::tct_sts_t sts,
	output tct_pkg::tct_cmd_t ctl
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_REL = 3'd2;
	localparam logic [2:0] S_MAIN = 3'd3;
	localparam logic [2:0] S_EOL = 3'd4;
	localparam logic [2:0] S_SUM = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.need_release) begin
					ctl.rel_start = 1'b1;
					state_d = S_REL;
				end else begin
					state_d = S_MAIN;
				end
			end
			S_REL: begin
				if (!sts.emit_en || sts.out_free) begin
					ctl.rel_step = 1'b1;
					if (sts.rel_last) begin
						state_d = S_MAIN;
					end
				end
			end
			S_MAIN: begin
				if (!sts.main_emit || sts.out_free) begin
					ctl.main = 1'b1;
					state_d = sts.eol ? S_EOL : S_IDLE;
				end
			end
			S_EOL: begin
				if (!(sts.bs_needed && sts.emit_en) || sts.out_free) begin
					ctl.eol_bs = sts.bs_needed;
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				if (sts.out_free) begin
					ctl.summary = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[design/tct_dp.sv]
`default_nettype none

module tct_dp #(
	parameter int HOLD_DEPTH = tct_pkg::HOLD_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [7:0] byte_value,
	input logic byte_valid,
	input logic end_of_command,
	input tct_pkg::tct_cmd_t ctl,
	output tct_pkg::tct_sts_t sts,
	output logic res_valid,
	input logic res_ready,
	output tct_pkg::tct_res_t res
);

	localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
	localparam int CW = $clog2(HOLD_DEPTH + 1);

	logic [7:0] byte_q;
	logic bvalid_q;
	logic eol_q;

	logic [1:0] mode_q, mode_d;
	logic esc_q, esc_d;
	logic escsp_q, escsp_d;
	logic [CW-1:0] hcount_q, hcount_d;
	logic [1:0] tc_q, tc_d;
	logic thb_q, thb_d;
	logic [tct_pkg::KW_NUM-1:0] mask_q, mask_d;
	logic [2:0] ftl_q, ftl_d;
	logic ovf_q, ovf_d;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] raddr;
	logic [7:0] rdata;

	logic res_valid_q;
	tct_pkg::tct_res_t res_q;
	tct_pkg::tct_res_t res_d;

	logic ws, is_quote, is_bslash;
	logic [2:0] code_now;
	logic emit_en;
	logic ap_main;
	logic ap_do;
	logic [7:0] ap_byte;
	logic byte_emit;
	logic byte_last;
	logic rel_last;
	logic out_free;
	logic hold_do;
	logic hold_wr;
	logic end_tok;
	logic [1:0] tc_fin;
	logic [2:0] code_fin;
	logic [1:0] need;

	always_comb begin
		ws = tct_pkg::is_ws(byte_q);
		is_quote = (byte_q == tct_pkg::CH_QUOTE);
		is_bslash = (byte_q == tct_pkg::CH_BACKSLASH);
		code_now = tct_pkg::cmd_code(tc_q, mask_q, ftl_q);
		case (code_now) inside
			tct_pkg::CMD_SET, tct_pkg::CMD_EXPIRE: emit_en = (tc_q == 2'd1) || (tc_q == 2'd2);
			tct_pkg::CMD_GET, tct_pkg::CMD_DEL, tct_pkg::CMD_TTL: emit_en = (tc_q == 2'd1);
			default: emit_en = 1'b0;
		endcase
		case (mode_q)
			tct_pkg::MODE_PLAIN: ap_main = !ws;
			tct_pkg::MODE_QUOTED: ap_main = !ws && (esc_q || (!is_quote && !is_bslash));
			default: ap_main = !ws && !is_quote;
		endcase
		ap_main = ap_main && bvalid_q;
		rel_last = (CW'(idx_q) + CW'(1)) == hcount_q;
		out_free = !res_valid_q || res_ready;

		ap_do = ctl.rel_step || ctl.eol_bs || (ctl.main && ap_main);
		if (ctl.rel_step) begin
			ap_byte = rdata;
		end else if (ctl.eol_bs) begin
			ap_byte = tct_pkg::CH_BACKSLASH;
		end else begin
			ap_byte = byte_q;
		end
		if (ctl.rel_step) begin
			byte_last = rel_last && (is_quote || is_bslash) && !eol_q;
		end else if (ctl.eol_bs) begin
			byte_last = 1'b0;
		end else begin
			byte_last = !eol_q;
		end
		byte_emit = ap_do && emit_en;

		tc_fin = (thb_q && tc_q != 2'd3) ? tc_q + 2'd1 : tc_q;
		code_fin = tct_pkg::cmd_code(tc_fin, mask_q, ftl_q);
		case (code_fin) inside
			tct_pkg::CMD_SET, tct_pkg::CMD_EXPIRE: need = 2'd3;
			tct_pkg::CMD_GET, tct_pkg::CMD_DEL, tct_pkg::CMD_TTL: need = 2'd2;
			default: need = 2'd0;
		endcase
	end

	always_comb begin
		sts.need_release = bvalid_q && mode_q == tct_pkg::MODE_QUOTED && !esc_q && !ws
			&& hcount_q != '0;
		sts.rel_last = rel_last;
		sts.main_emit = ap_main && emit_en;
		sts.emit_en = emit_en;
		sts.bs_needed = (mode_q == tct_pkg::MODE_QUOTED) && (esc_q || escsp_q);
		sts.eol = eol_q;
		sts.out_free = out_free;
	end

	// scanner state update
	always_comb begin
		mode_d = mode_q;
		esc_d = esc_q;
		escsp_d = escsp_q;
		hcount_d = hcount_q;
		tc_d = tc_q;
		thb_d = thb_q;
		mask_d = mask_q;
		ftl_d = ftl_q;
		ovf_d = ovf_q;
		hold_do = 1'b0;
		end_tok = 1'b0;
		if (ctl.main && bvalid_q) begin
			case (mode_q)
				tct_pkg::MODE_PLAIN: begin
					end_tok = ws;
				end
				tct_pkg::MODE_QUOTED: begin
					if (esc_q) begin
						esc_d = 1'b0;
						if (ws) begin
							escsp_d = 1'b1;
							hold_do = 1'b1;
						end
					end else if (ws) begin
						hold_do = 1'b1;
					end else begin
						escsp_d = 1'b0;
						hcount_d = '0;
						if (is_quote) begin
							end_tok = 1'b1;
						end else if (is_bslash) begin
							esc_d = 1'b1;
						end
					end
				end
				default: begin
					if (!ws) begin
						thb_d = 1'b0;
						mode_d = is_quote ? tct_pkg::MODE_QUOTED : tct_pkg::MODE_PLAIN;
					end
				end
			endcase
		end
		hold_wr = hold_do && (hcount_q < CW'(HOLD_DEPTH));
		if (hold_do) begin
			if (hcount_q < CW'(HOLD_DEPTH)) begin
				hcount_d = hcount_q + CW'(1);
			end else begin
				ovf_d = 1'b1;
			end
		end
		if (end_tok) begin
			if (thb_q && tc_q != 2'd3) begin
				tc_d = tc_q + 2'd1;
			end
			thb_d = 1'b0;
			mode_d = tct_pkg::MODE_BETWEEN;
		end
		if (ap_do) begin
			if (tc_q == 2'd0) begin
				mask_d = tct_pkg::kw_mask_next(mask_q, ftl_q, ap_byte);
				if (ftl_q != 3'd7) begin
					ftl_d = ftl_q + 3'd1;
				end
			end
			thb_d = 1'b1;
		end
		if (ctl.summary) begin
			mode_d = tct_pkg::MODE_BETWEEN;
			esc_d = 1'b0;
			escsp_d = 1'b0;
			hcount_d = '0;
			tc_d = '0;
			thb_d = 1'b0;
			mask_d = '1;
			ftl_d = '0;
			ovf_d = 1'b0;
		end
	end

	always_comb begin
		res_d = '0;
		if (ctl.summary) begin
			res_d.kind = 1'b1;
			res_d.command_code = code_fin;
			res_d.args_complete = (tc_fin >= need);
			res_d.hold_overflow = ovf_q;
			res_d.last = 1'b1;
		end else begin
			res_d.arg_index = tc_q[1];
			res_d.arg_byte = ap_byte;
			res_d.arg_start = !thb_q;
			res_d.command_code = tct_pkg::CMD_UNKNOWN;
			res_d.last = byte_last;
		end
	end

	always_comb begin
		if (ctl.rel_start) begin
			raddr = '0;
		end else if (ctl.rel_step && !rel_last) begin
			raddr = idx_q + AW'(1);
		end else begin
			raddr = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			eol_q <= 1'b0;
			mode_q <= tct_pkg::MODE_BETWEEN;
			esc_q <= 1'b0;
			escsp_q <= 1'b0;
			hcount_q <= '0;
			tc_q <= '0;
			thb_q <= 1'b0;
			mask_q <= '1;
			ftl_q <= '0;
			ovf_q <= 1'b0;
			idx_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				bvalid_q <= byte_valid;
				eol_q <= end_of_command;
			end
			mode_q <= mode_d;
			esc_q <= esc_d;
			escsp_q <= escsp_d;
			hcount_q <= hcount_d;
			tc_q <= tc_d;
			thb_q <= thb_d;
			mask_q <= mask_d;
			ftl_q <= ftl_d;
			ovf_q <= ovf_d;
			idx_q <= raddr;
			if (byte_emit || ctl.summary) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			byte_q <= byte_value;
		end
		if (byte_emit || ctl.summary) begin
			res_q <= res_d;
		end
	end

	tct_ram #(
		.WIDTH(8),
		.DEPTH(HOLD_DEPTH)
	) u_hold_ram (
		.clk(clk),
		.we(hold_wr),
		.waddr(hcount_q[AW-1:0]),
		.wdata(byte_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

`default_nettype wire

[test/tb_text_command_tokenizer.sv]
`default_nettype none

module tb_text_command_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 2000;
	localparam int ITEM_TARGET = 370;
	localparam int HELD_MAX = tct_pkg::HOLD_DEPTH_DEF;

	typedef struct packed {
		logic [7:0] value;
		logic valid;
		logic eoc;
		logic pause;
	} cmd_item_t;

	typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_PATTERN, RDY_SPARSE} rdy_mode_t;

	localparam logic [2:0] KW_CODE [7] = '{tct_pkg::CMD_PING, tct_pkg::CMD_SET,
		tct_pkg::CMD_GET, tct_pkg::CMD_DEL, tct_pkg::CMD_EXPIRE, tct_pkg::CMD_TTL,
		tct_pkg::CMD_STATS};

	logic clk = 1'b0;
	logic arst_n;

	tct_cmd_if cmd_bus();
	tct_tok_if tok_bus();

	text_command_tokenizer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.tok(tok_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// scanner state of the line being tokenized
	logic [1:0] sc_mode = tct_pkg::MODE_BETWEEN;
	logic sc_esc = 1'b0;
	logic sc_esc_ws = 1'b0;
	logic [7:0] sc_held [HELD_MAX];
	int sc_held_n = 0;
	int sc_tokens = 0;
	logic sc_has = 1'b0;
	logic [6:0] sc_mask = '1;
	int sc_len = 0;
	logic sc_ovf = 1'b0;

	tct_pkg::tct_res_t step_q[$];
	tct_pkg::tct_res_t awaited_q[$];
	cmd_item_t cmd_pend_q[$];

	int n_items = 0;
	int n_accepted = 0;
	int n_lines = 0;
	int n_arg_bytes = 0;
	int n_ovf_lines = 0;
	int n_pauses = 0;
	int n_bad = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_tick = 0;
	logic [7:0] stall_pat = 8'h01;
	rdy_mode_t stall_mode = RDY_ALWAYS;
	logic [7:0] codes_seen = '0;
	logic cmd_fire = 1'b0;

	function automatic string kw_word(input int k);
		case (k)
			0: return "PING";
			1: return "SET";
			2: return "GET";
			3: return "DEL";
			4: return "EXPIRE";
			5: return "TTL";
			default: return "STATS";
		endcase
	endfunction

	function automatic logic blank(input logic [7:0] b);
		return b == tct_pkg::CH_SPACE || (b >= tct_pkg::CH_TAB && b <= tct_pkg::CH_CR);
	endfunction

	function automatic logic [2:0] line_code();
		string w;
		if (sc_tokens == 0) begin
			return tct_pkg::CMD_UNKNOWN;
		end
		for (int k = 0; k < 7; k++) begin
			w = kw_word(k);
			if (sc_mask[k] && w.len() == sc_len) begin
				return KW_CODE[k];
			end
		end
		return tct_pkg::CMD_UNKNOWN;
	endfunction

	task automatic clear_scan();
		sc_mode = tct_pkg::MODE_BETWEEN;
		sc_esc = 1'b0;
		sc_esc_ws = 1'b0;
		sc_held_n = 0;
		sc_tokens = 0;
		sc_has = 1'b0;
		sc_mask = '1;
		sc_len = 0;
		sc_ovf = 1'b0;
	endtask

	task automatic add_byte(input logic [7:0] b);
		logic [7:0] up;
		logic [2:0] c;
		logic take;
		string w;
		tct_pkg::tct_res_t r;
		if (sc_tokens == 0) begin
			up = (b >= tct_pkg::CH_LOWER_A && b <= tct_pkg::CH_LOWER_Z)
				? b - tct_pkg::CASE_OFFSET : b;
			for (int k = 0; k < 7; k++) begin
				w = kw_word(k);
				if (sc_len >= w.len() || w[sc_len] != up) begin
					sc_mask[k] = 1'b0;
				end
			end
			if (sc_len < 7) begin
				sc_len++;
			end
		end else if (sc_tokens <= 2) begin
			c = line_code();
			if (sc_tokens == 1) begin
				take = c == tct_pkg::CMD_SET || c == tct_pkg::CMD_GET || c == tct_pkg::CMD_DEL
					|| c == tct_pkg::CMD_EXPIRE || c == tct_pkg::CMD_TTL;
			end else begin
				take = c == tct_pkg::CMD_SET || c == tct_pkg::CMD_EXPIRE;
			end
			if (take) begin
				r = '0;
				r.arg_index = sc_tokens == 2;
				r.arg_byte = b;
				r.arg_start = !sc_has;
				step_q.insert(step_q.size(), r);
			end
		end
		sc_has = 1'b1;
	endtask

	task automatic flush_held();
		for (int i = 0; i < sc_held_n && i < HELD_MAX; i++) begin
			add_byte(sc_held[i]);
		end
		sc_held_n = 0;
		sc_esc_ws = 1'b0;
	endtask

	task automatic hold_ws(input logic [7:0] b);
		if (sc_held_n < HELD_MAX) begin
			sc_held[sc_held_n] = b;
			sc_held_n++;
		end else begin
			sc_ovf = 1'b1;
		end
	endtask

	task automatic close_token();
		if (sc_has && sc_tokens < 3) begin
			sc_tokens++;
		end
		sc_has = 1'b0;
		sc_mode = tct_pkg::MODE_BETWEEN;
	endtask

	// expected tok transfers caused by one cmd transfer
	task automatic tokenize_byte(input logic [7:0] b, input logic bv, input logic eoc);
		tct_pkg::tct_res_t r;
		logic [2:0] c;
		int need;
		step_q.delete();
		if (bv) begin
			if (sc_mode == tct_pkg::MODE_PLAIN) begin
				if (blank(b)) begin
					close_token();
				end else begin
					add_byte(b);
				end
			end else if (sc_mode == tct_pkg::MODE_QUOTED) begin
				if (sc_esc) begin
					sc_esc = 1'b0;
					if (blank(b)) begin
						sc_esc_ws = 1'b1;
						hold_ws(b);
					end else begin
						add_byte(b);
					end
				end else if (blank(b)) begin
					hold_ws(b);
				end else if (b == tct_pkg::CH_QUOTE) begin
					flush_held();
					close_token();
				end else if (b == tct_pkg::CH_BACKSLASH) begin
					flush_held();
					sc_esc = 1'b1;
				end else begin
					flush_held();
					add_byte(b);
				end
			end else if (!blank(b)) begin
				sc_has = 1'b0;
				if (b == tct_pkg::CH_QUOTE) begin
					sc_mode = tct_pkg::MODE_QUOTED;
				end else begin
					sc_mode = tct_pkg::MODE_PLAIN;
					add_byte(b);
				end
			end
		end
		if (eoc) begin
			if (sc_mode == tct_pkg::MODE_QUOTED) begin
				sc_held_n = 0;
				if (sc_esc || sc_esc_ws) begin
					add_byte(tct_pkg::CH_BACKSLASH);
				end
			end
			close_token();
			c = line_code();
			if (c == tct_pkg::CMD_SET || c == tct_pkg::CMD_EXPIRE) begin
				need = 3;
			end else if (c == tct_pkg::CMD_GET || c == tct_pkg::CMD_DEL
					|| c == tct_pkg::CMD_TTL) begin
				need = 2;
			end else begin
				need = 0;
			end
			r = '0;
			r.kind = 1'b1;
			r.command_code = c;
			r.args_complete = sc_tokens >= need;
			r.hold_overflow = sc_ovf;
			step_q.insert(step_q.size(), r);
			clear_scan();
		end
		if (step_q.size() > 0) begin
			r = step_q[step_q.size() - 1];
			r.last = 1'b1;
			step_q[step_q.size() - 1] = r;
		end
		foreach (step_q[i]) begin
			awaited_q.insert(awaited_q.size(), step_q[i]);
		end
	endtask

	// stimulus building
	task automatic put_item(input logic [7:0] v, input logic bv, input logic eoc,
			input logic pause);
		cmd_item_t it;
		it = '{v, bv, eoc, pause};
		cmd_pend_q.insert(cmd_pend_q.size(), it);
		if (bv || eoc) begin
			n_items++;
		end
	endtask

	task automatic put_byte(input logic [7:0] b);
		put_item(b, 1'b1, 1'b0, 1'b0);
		if ($urandom_range(15, 0) == 0) begin
			put_item(8'($urandom_range(255, 0)), 1'b0, 1'b0, 1'b0);
		end
	endtask

	task automatic put_ws();
		if ($urandom_range(2, 0) == 0) begin
			put_byte(8'(tct_pkg::CH_TAB + $urandom_range(4, 0)));
		end else begin
			put_byte(tct_pkg::CH_SPACE);
		end
	endtask

	task automatic put_text(input string s, input logic mix_case);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix_case && (c | tct_pkg::CASE_OFFSET) >= tct_pkg::CH_LOWER_A
					&& (c | tct_pkg::CASE_OFFSET) <= tct_pkg::CH_LOWER_Z
					&& $urandom_range(1, 0)) begin
				c = c ^ tct_pkg::CASE_OFFSET;
			end
			put_byte(c);
		end
	endtask

	task automatic put_plain();
		repeat ($urandom_range(6, 1)) begin
			put_byte(8'($urandom_range(126, 33)));
		end
	endtask

	task automatic put_quoted(input logic long_ws);
		put_byte(tct_pkg::CH_QUOTE);
		repeat ($urandom_range(6, 0)) begin
			case ($urandom_range(5, 0)) inside
				0, 1: put_byte(8'($urandom_range(126, 33)));
				2: repeat ($urandom_range(3, 1)) put_ws();
				3: begin
					put_byte(tct_pkg::CH_BACKSLASH);
					put_byte(8'($urandom_range(255, 0)));
				end
				4: begin
					put_byte(tct_pkg::CH_BACKSLASH);
					put_ws();
				end
				default: put_byte(8'(tct_pkg::CH_LOWER_A + $urandom_range(25, 0)));
			endcase
		end
		if (long_ws) begin
			repeat ($urandom_range(20, 13)) put_ws();
			put_byte(8'(tct_pkg::CH_LOWER_A + $urandom_range(25, 0)));
		end
		if ($urandom_range(7, 0) != 0) begin
			put_byte(tct_pkg::CH_QUOTE);
		end
	endtask

	task automatic put_eol();
		cmd_item_t it;
		if (cmd_pend_q.size() > 0 && $urandom_range(1, 0)) begin
			it = cmd_pend_q[cmd_pend_q.size() - 1];
			if (it.valid && !it.pause) begin
				it.eoc = 1'b1;
				cmd_pend_q[cmd_pend_q.size() - 1] = it;
				return;
			end
		end
		put_item(8'($urandom_range(255, 0)), 1'b0, 1'b1, 1'b0);
	endtask

	task automatic put_line();
		int pick;
		string w;
		if ($urandom_range(9, 0) == 0) begin
			repeat ($urandom_range(10, 1)) put_byte(8'($urandom_range(255, 0)));
		end else begin
			if ($urandom_range(3, 0) == 0) begin
				put_ws();
			end
			pick = $urandom_range(11, 0);
			w = kw_word($urandom_range(6, 0));
			case (pick)
				7: begin
					put_byte(tct_pkg::CH_QUOTE);
					put_text(w, 1'b1);
					put_byte(tct_pkg::CH_QUOTE);
				end
				8: put_text({w, "X"}, 1'b1);
				9: put_text(w.substr(0, w.len() - 2), 1'b1);
				10: put_plain();
				11: put_text({w, w}, 1'b1);
				default: put_text(kw_word(pick), 1'b1);
			endcase
			repeat ($urandom_range(4, 0)) begin
				repeat ($urandom_range(2, 1)) put_ws();
				case ($urandom_range(9, 0)) inside
					6, 7: put_quoted(1'b0);
					8: put_quoted(1'b1);
					9: begin
						put_byte(tct_pkg::CH_QUOTE);
						put_byte(tct_pkg::CH_QUOTE);
					end
					default: put_plain();
				endcase
			end
			if ($urandom_range(3, 0) == 0) begin
				put_ws();
			end
		end
		put_eol();
		if ($urandom_range(11, 0) == 0) begin
			put_item(8'h00, 1'b0, 1'b0, 1'b1);
		end
	endtask

	// cmd driver
	always @(negedge clk) begin
		cmd_item_t it;
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			cmd_bus.byte_value <= 8'h00;
			cmd_bus.byte_valid <= 1'b0;
			cmd_bus.end_of_command <= 1'b0;
		end else if (!cmd_bus.valid || cmd_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_bus.valid <= 1'b0;
			end else if (cmd_pend_q.size() == 0) begin
				cmd_bus.valid <= 1'b0;
			end else if (cmd_pend_q[0].pause) begin
				cmd_bus.valid <= 1'b0;
				if (awaited_q.size() == 0) begin
					it = cmd_pend_q.pop_front();
					n_pauses++;
				end
			end else begin
				it = cmd_pend_q.pop_front();
				cmd_bus.valid <= 1'b1;
				cmd_bus.byte_value <= it.value;
				cmd_bus.byte_valid <= it.valid;
				cmd_bus.end_of_command <= it.eoc;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 10)
						: $urandom_range(12, 1);
					gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
				end
			end
		end
	end

	// tok ready, stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			tok_bus.ready <= 1'b0;
		end else begin
			if (stall_tick == 0) begin
				stall_mode = rdy_mode_t'($urandom_range(3, 0));
				stall_pat = 8'($urandom_range(255, 1));
				stall_tick = $urandom_range(80, 20);
			end else begin
				stall_tick--;
			end
			case (stall_mode)
				RDY_ALWAYS: tok_bus.ready <= 1'b1;
				RDY_COIN: tok_bus.ready <= 1'($urandom_range(1, 0));
				RDY_PATTERN: begin
					tok_bus.ready <= stall_pat[0];
					stall_pat = {stall_pat[0], stall_pat[7:1]};
				end
				default: tok_bus.ready <= ($urandom_range(3, 0) == 0);
			endcase
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		tct_pkg::tct_res_t got;
		tct_pkg::tct_res_t want;
		if (arst_n) begin
			cmd_fire <= cmd_bus.valid && cmd_bus.ready;
			idle_cycles++;
			if (cmd_bus.valid && cmd_bus.ready) begin
				idle_cycles = 0;
				n_accepted++;
				tokenize_byte(cmd_bus.byte_value, cmd_bus.byte_valid, cmd_bus.end_of_command);
			end
			if (tok_bus.valid && tok_bus.ready) begin
				idle_cycles = 0;
				got = '{tok_bus.kind, tok_bus.arg_index, tok_bus.arg_byte, tok_bus.arg_start,
					tok_bus.command_code, tok_bus.args_complete, tok_bus.hold_overflow,
					tok_bus.last};
				if (awaited_q.size() == 0) begin
					if (n_bad < 10) begin
						$display("unexpected tok transfer: kind=%0d byte=%02h code=%0d last=%0d",
							got.kind, got.arg_byte, got.command_code, got.last);
					end
					n_bad++;
				end else begin
					want = awaited_q.pop_front();
					if (got !== want) begin
						if (n_bad < 10) begin
							$display("tok mismatch exp: kind=%0d idx=%0d byte=%02h start=%0d",
								want.kind, want.arg_index, want.arg_byte, want.arg_start,
								" code=%0d comp=%0d ovf=%0d last=%0d",
								want.command_code, want.args_complete, want.hold_overflow,
								want.last);
							$display("tok mismatch got: kind=%0d idx=%0d byte=%02h start=%0d",
								got.kind, got.arg_index, got.arg_byte, got.arg_start,
								" code=%0d comp=%0d ovf=%0d last=%0d",
								got.command_code, got.args_complete, got.hold_overflow,
								got.last);
						end
						n_bad++;
					end
					if (got.kind) begin
						n_lines++;
						codes_seen[got.command_code] = 1'b1;
						if (got.hold_overflow) begin
							n_ovf_lines++;
						end
					end else begin
						n_arg_bytes++;
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[text_command_tokenizer] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;

		// no byte and no end, then an empty line
		put_item(8'hFF, 1'b0, 1'b0, 1'b0);
		put_item(8'h00, 1'b0, 1'b1, 1'b0);
		// backslash then whitespace at end of an open quote
		put_text("gET \"\\ ", 1'b0);
		put_item(tct_pkg::CH_SPACE, 1'b1, 1'b1, 1'b0);
		// quote inside a plain token, top byte value
		put_text("dEl k\"x", 1'b0);
		put_item(8'hFF, 1'b1, 1'b0, 1'b0);
		put_item(8'hFF, 1'b0, 1'b1, 1'b0);
		// empty quoted token is dropped
		put_text("ttl \"", 1'b0);
		put_item(tct_pkg::CH_QUOTE, 1'b1, 1'b1, 1'b0);
		put_item(8'h00, 1'b1, 1'b1, 1'b0);
		put_item(8'h00, 1'b0, 1'b0, 1'b1);

		while (n_items < ITEM_TARGET) begin
			put_line();
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_pend_q.size() != 0 || cmd_bus.valid || awaited_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (40) @(negedge clk);

		$display("covered %0d cmd transfers, %0d lines, %0d argument bytes, %0d drain pauses",
			n_accepted, n_lines, n_arg_bytes, n_pauses);
		$display("command codes seen %b, lines with hold overflow %0d, mismatches %0d",
			codes_seen, n_ovf_lines, n_bad);
		if (n_bad == 0 && awaited_q.size() == 0) begin
			$display("[text_command_tokenizer] OK");
		end else begin
			$display("[text_command_tokenizer] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

[text_command_tokenizer.f]
design/tct_pkg.sv
design/tct_cmd_if.sv
design/tct_tok_if.sv
design/tct_ram.sv
design/tct_ctrl.sv
design/tct_dp.sv
design/text_command_tokenizer.sv
test/tb_text_command_tokenizer.sv
